>>> src/tlca_pkg.sv
package tlca_pkg;

	localparam int NODES = 1024;
	localparam int JUMP_LEVELS = 10;
	localparam int NODE_W = $clog2(NODES);
	localparam int LVL_W = $clog2(JUMP_LEVELS);
	localparam int CNT_W = NODE_W + 1;
	localparam int JADDR_W = NODE_W + LVL_W;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_KILL = 2'd1;

	localparam logic [1:0] ST_QUERY = 2'd0;
	localparam logic [1:0] ST_ADDED = 2'd1;
	localparam logic [1:0] ST_KILLED = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DEC, S_ADD0, S_ADDW, S_KILL,
		S_QA, S_QB, S_QS, S_LJ, S_LD, S_LC, S_CHK,
		S_PA, S_PB, S_PC, S_PF, S_PG, S_DR, S_DC, S_WC, S_FIN
	} state_t;

	typedef struct packed {
		state_t op;
		logic take;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_add;
		logic is_kill;
		logic full;
		logic add_last;
		logic depth_eq;
		logic lvl_zero;
		logic a_eq_b;
		logic dead;
		logic walk_go;
	} dp_stat_t;

endpackage

>>> src/tree_lca_with_dead_nodes_top.sv
// Lowest common ancestor engine for a growing tree whose root is node 1.
// Request channel: req_valid, req_stall, with command, node_a and node_b.
// A word is taken when req_valid is high and req_stall is low.
// Command add attaches the next free node under node_a (or reports full),
// kill marks node_a dead unless it is the root, and query returns the
// nearest live common ancestor of both nodes. Response channel: rsp_valid,
// rsp_stall, with answer_node and status; one word per request, in order.
// One request is worked at a time; cost is set by the single read port of
// the jump table and the depth memory, and a query also pays for each dead
// ancestor walked over.
// After reset the block clears its dead flags and loads the root row, one
// entry a cycle over all 1024 nodes, with req_stall high.
// The finished response sits in an output register, so the next request is
// taken while it waits; a request that finishes while rsp_stall still holds
// the earlier word waits until that word is taken.
module tree_lca_with_dead_nodes_top (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  logic [1:0] command,
	input  logic [9:0] node_a,
	input  logic [9:0] node_b,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [9:0] answer_node,
	output logic [1:0] status
);

	tlca_pkg::dp_cmd_t cmd;
	tlca_pkg::dp_stat_t stat;

	tlca_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.stat(stat),
		.cmd(cmd)
	);

	tlca_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.command(command),
		.node_a(node_a),
		.node_b(node_b),
		.answer_node(answer_node),
		.status(status)
	);

	a_take_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> cmd.op == tlca_pkg::S_DEC)
		else $error("accepted request did not reach decode");

	a_add_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == tlca_pkg::S_ADD0 |-> !stat.full)
		else $error("add started on a full table");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == tlca_pkg::ST_FULL |-> answer_node == '0)
		else $error("full status with nonzero node");

endmodule

>>> src/tlca_ctrl.sv
module tlca_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  tlca_pkg::dp_stat_t stat,
	output tlca_pkg::dp_cmd_t cmd
);

	tlca_pkg::state_t state_q, state_d;
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlca_pkg::S_CLR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tlca_pkg::S_CLR: if (stat.clr_done) state_d = tlca_pkg::S_IDLE;
			tlca_pkg::S_IDLE: if (req_valid) state_d = tlca_pkg::S_DEC;
			tlca_pkg::S_DEC: begin
				if (stat.is_add) begin
					state_d = stat.full ? tlca_pkg::S_FIN : tlca_pkg::S_ADD0;
				end else if (stat.is_kill) begin
					state_d = tlca_pkg::S_KILL;
				end else begin
					state_d = tlca_pkg::S_QA;
				end
			end
			tlca_pkg::S_ADD0: state_d = tlca_pkg::S_ADDW;
			tlca_pkg::S_ADDW: if (stat.add_last) state_d = tlca_pkg::S_FIN;
			tlca_pkg::S_KILL: state_d = tlca_pkg::S_FIN;
			tlca_pkg::S_QA: state_d = tlca_pkg::S_QB;
			tlca_pkg::S_QB: state_d = tlca_pkg::S_QS;
			tlca_pkg::S_QS: state_d = tlca_pkg::S_LJ;
			tlca_pkg::S_LJ: state_d = stat.depth_eq ? tlca_pkg::S_CHK : tlca_pkg::S_LD;
			tlca_pkg::S_LD: state_d = tlca_pkg::S_LC;
			tlca_pkg::S_LC: state_d = stat.lvl_zero ? tlca_pkg::S_CHK : tlca_pkg::S_LJ;
			tlca_pkg::S_CHK: state_d = stat.a_eq_b ? tlca_pkg::S_DR : tlca_pkg::S_PA;
			tlca_pkg::S_PA: state_d = tlca_pkg::S_PB;
			tlca_pkg::S_PB: state_d = tlca_pkg::S_PC;
			tlca_pkg::S_PC: state_d = stat.lvl_zero ? tlca_pkg::S_PF : tlca_pkg::S_PA;
			tlca_pkg::S_PF: state_d = tlca_pkg::S_PG;
			tlca_pkg::S_PG: state_d = tlca_pkg::S_DR;
			tlca_pkg::S_DR: state_d = tlca_pkg::S_DC;
			tlca_pkg::S_DC: state_d = stat.dead ? tlca_pkg::S_WC : tlca_pkg::S_FIN;
			tlca_pkg::S_WC: if (!stat.walk_go) state_d = tlca_pkg::S_FIN;
			tlca_pkg::S_FIN: if (cmd.load_out) state_d = tlca_pkg::S_IDLE;
			default: state_d = tlca_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = state_q;
		cmd.take = (state_q == tlca_pkg::S_IDLE) && req_valid;
		cmd.load_out = (state_q == tlca_pkg::S_FIN) && (!rsp_valid_q || !rsp_stall);
		req_stall = (state_q != tlca_pkg::S_IDLE);
		rsp_valid = rsp_valid_q;
	end

endmodule

>>> src/tlca_dp.sv
module tlca_dp (
	input  logic clk,
	input  logic arst_n,
	input  tlca_pkg::dp_cmd_t cmd,
	output tlca_pkg::dp_stat_t stat,
	input  logic [1:0] command,
	input  logic [9:0] node_a,
	input  logic [9:0] node_b,
	output logic [9:0] answer_node,
	output logic [1:0] status
);

	localparam int JROWS = tlca_pkg::NODES << tlca_pkg::LVL_W;

	logic [tlca_pkg::NODE_W-1:0] depth_mem [tlca_pkg::NODES];
	logic [tlca_pkg::NODE_W-1:0] jump_mem [JROWS];
	logic [tlca_pkg::NODE_W-1:0] parent_mem [tlca_pkg::NODES];
	logic dead_mem [tlca_pkg::NODES];

	logic [tlca_pkg::NODE_W-1:0] depth_rd, jump_rd, parent_rd;
	logic dead_rd;

	logic depth_we, jump_we, parent_we, dead_we;
	logic [tlca_pkg::NODE_W-1:0] depth_wa, depth_wd, depth_ra;
	logic [tlca_pkg::JADDR_W-1:0] jump_wa, jump_ra;
	logic [tlca_pkg::NODE_W-1:0] jump_wd;
	logic [tlca_pkg::NODE_W-1:0] parent_wa, parent_wd, parent_ra;
	logic [tlca_pkg::NODE_W-1:0] dead_wa, dead_ra;
	logic dead_wd;

	logic [tlca_pkg::CNT_W-1:0] next_q, steps_q;
	logic [tlca_pkg::NODE_W-1:0] clr_q;
	logic [1:0] cmd_q;
	logic [tlca_pkg::NODE_W-1:0] a_q, b_q, da_q, db_q, t_q, ja_q, c_q, v_q;
	logic [tlca_pkg::LVL_W-1:0] lvl_q;
	logic [9:0] res_ans_q, answer_q;
	logic [1:0] res_st_q, status_q;
	logic [tlca_pkg::NODE_W-1:0] new_node;

	assign new_node = next_q[tlca_pkg::NODE_W-1:0];

	always_comb begin
		stat.clr_done = (clr_q == {tlca_pkg::NODE_W{1'b1}});
		stat.is_add = (cmd_q == tlca_pkg::CMD_ADD);
		stat.is_kill = (cmd_q == tlca_pkg::CMD_KILL);
		stat.full = (next_q >= tlca_pkg::CNT_W'(tlca_pkg::NODES));
		stat.add_last = (lvl_q == tlca_pkg::LVL_W'(tlca_pkg::JUMP_LEVELS - 1));
		stat.depth_eq = (da_q == db_q);
		stat.lvl_zero = (lvl_q == '0);
		stat.a_eq_b = (a_q == b_q);
		stat.dead = dead_rd;
		stat.walk_go = dead_rd && (steps_q != tlca_pkg::CNT_W'(tlca_pkg::NODES));
	end

	always_comb begin
		depth_we = 1'b0;
		depth_wa = new_node;
		depth_wd = depth_rd + tlca_pkg::NODE_W'(1);
		depth_ra = a_q;
		jump_we = 1'b0;
		jump_wa = {new_node, lvl_q};
		jump_wd = jump_rd;
		jump_ra = {a_q, lvl_q};
		parent_we = 1'b0;
		parent_wa = c_q;
		parent_wd = v_q;
		parent_ra = c_q;
		dead_we = 1'b0;
		dead_wa = a_q;
		dead_wd = 1'b1;
		dead_ra = c_q;
		case (cmd.op)
			tlca_pkg::S_CLR: begin
				dead_we = 1'b1;
				dead_wa = clr_q;
				dead_wd = 1'b0;
				depth_we = (clr_q == tlca_pkg::NODE_W'(1));
				depth_wa = clr_q;
				depth_wd = '0;
				jump_we = (clr_q < tlca_pkg::NODE_W'(tlca_pkg::JUMP_LEVELS));
				jump_wa = {tlca_pkg::NODE_W'(1), clr_q[tlca_pkg::LVL_W-1:0]};
				jump_wd = tlca_pkg::NODE_W'(1);
			end
			tlca_pkg::S_ADD0: begin
				jump_ra = {a_q, tlca_pkg::LVL_W'(0)};
				jump_we = 1'b1;
				jump_wa = {new_node, tlca_pkg::LVL_W'(0)};
				jump_wd = a_q;
				parent_we = 1'b1;
				parent_wa = new_node;
				parent_wd = a_q;
			end
			tlca_pkg::S_ADDW: begin
				jump_we = 1'b1;
				jump_ra = {jump_rd, lvl_q};
				depth_we = (lvl_q == tlca_pkg::LVL_W'(1));
			end
			tlca_pkg::S_KILL: dead_we = (a_q != tlca_pkg::NODE_W'(1));
			tlca_pkg::S_QB: depth_ra = b_q;
			tlca_pkg::S_LD: depth_ra = jump_rd;
			tlca_pkg::S_PB: jump_ra = {b_q, lvl_q};
			tlca_pkg::S_PF: jump_ra = {a_q, tlca_pkg::LVL_W'(0)};
			tlca_pkg::S_DC: begin
				dead_ra = parent_rd;
				parent_ra = parent_rd;
			end
			tlca_pkg::S_WC: begin
				dead_ra = parent_rd;
				parent_ra = parent_rd;
				parent_we = !stat.walk_go;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (depth_we) depth_mem[depth_wa] <= depth_wd;
		depth_rd <= depth_mem[depth_ra];
	end

	always_ff @(posedge clk) begin
		if (jump_we) jump_mem[jump_wa] <= jump_wd;
		jump_rd <= jump_mem[jump_ra];
	end

	always_ff @(posedge clk) begin
		if (parent_we) parent_mem[parent_wa] <= parent_wd;
		parent_rd <= parent_mem[parent_ra];
	end

	always_ff @(posedge clk) begin
		if (dead_we) dead_mem[dead_wa] <= dead_wd;
		dead_rd <= dead_mem[dead_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= tlca_pkg::CNT_W'(2);
			clr_q <= '0;
		end else begin
			if (cmd.op == tlca_pkg::S_CLR) clr_q <= clr_q + tlca_pkg::NODE_W'(1);
			if (cmd.op == tlca_pkg::S_ADDW && stat.add_last) begin
				next_q <= next_q + tlca_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q <= command;
			a_q <= tlca_pkg::NODE_W'(node_a);
			b_q <= tlca_pkg::NODE_W'(node_b);
		end
		if (cmd.load_out) begin
			answer_q <= res_ans_q;
			status_q <= res_st_q;
		end
		case (cmd.op)
			tlca_pkg::S_DEC: begin
				res_ans_q <= '0;
				res_st_q <= tlca_pkg::ST_FULL;
			end
			tlca_pkg::S_ADD0: lvl_q <= tlca_pkg::LVL_W'(1);
			tlca_pkg::S_ADDW: begin
				lvl_q <= lvl_q + tlca_pkg::LVL_W'(1);
				res_ans_q <= 10'(new_node);
				res_st_q <= tlca_pkg::ST_ADDED;
			end
			tlca_pkg::S_KILL: begin
				res_ans_q <= 10'(a_q);
				res_st_q <= tlca_pkg::ST_KILLED;
			end
			tlca_pkg::S_QB: da_q <= depth_rd;
			tlca_pkg::S_QS: begin
				if (da_q < depth_rd) begin
					a_q <= b_q;
					b_q <= a_q;
					da_q <= depth_rd;
					db_q <= da_q;
				end else begin
					db_q <= depth_rd;
				end
				lvl_q <= tlca_pkg::LVL_W'(tlca_pkg::JUMP_LEVELS - 1);
			end
			tlca_pkg::S_LD: t_q <= jump_rd;
			tlca_pkg::S_LC: begin
				if (depth_rd >= db_q) begin
					a_q <= t_q;
					da_q <= depth_rd;
				end
				if (!stat.lvl_zero) lvl_q <= lvl_q - tlca_pkg::LVL_W'(1);
			end
			tlca_pkg::S_CHK: begin
				c_q <= a_q;
				lvl_q <= tlca_pkg::LVL_W'(tlca_pkg::JUMP_LEVELS - 1);
			end
			tlca_pkg::S_PB: ja_q <= jump_rd;
			tlca_pkg::S_PC: begin
				if (ja_q != jump_rd) begin
					a_q <= ja_q;
					b_q <= jump_rd;
				end
				if (!stat.lvl_zero) lvl_q <= lvl_q - tlca_pkg::LVL_W'(1);
			end
			tlca_pkg::S_PG: c_q <= jump_rd;
			tlca_pkg::S_DC: begin
				res_ans_q <= 10'(c_q);
				res_st_q <= tlca_pkg::ST_QUERY;
				v_q <= parent_rd;
				steps_q <= '0;
			end
			tlca_pkg::S_WC: begin
				if (stat.walk_go) begin
					v_q <= parent_rd;
					steps_q <= steps_q + tlca_pkg::CNT_W'(1);
				end else begin
					res_ans_q <= 10'(v_q);
					res_st_q <= tlca_pkg::ST_QUERY;
				end
			end
			default: ;
		endcase
	end

	assign answer_node = answer_q;
	assign status = status_q;

endmodule
